@@ src/pov_pkg.sv @@
`default_nettype none
package pov_pkg;

	localparam int FRAC_BITS   = 12;
	localparam int SAMPLE_BITS = 18;
	localparam int BASE_W      = SAMPLE_BITS + FRAC_BITS;
	localparam int HIST_DEPTH  = 5;
	localparam int HIST_FRAC   = 8;
	localparam int SLOT_W      = $clog2(HIST_DEPTH);
	localparam int HIST_W      = 15;
	localparam int SUM_W       = HIST_W + $clog2(HIST_DEPTH);

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 32;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DIV_N_W = 88;
	localparam int DIV_D_W = 64;
	localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

	// ema weights, each pair sums to one in q.12
	localparam logic [11:0] KEEP95 = 12'd3891;
	localparam logic [11:0] NEW05  = 12'd205;
	localparam logic [11:0] KEEP98 = 12'd4014;
	localparam logic [11:0] NEW02  = 12'd82;

	// calibration in q.12
	localparam logic [17:0] COEF_A = 18'd184566;
	localparam logic [16:0] COEF_B = 17'd124330;
	localparam logic [18:0] COEF_C = 19'd388485;

	typedef struct packed {
		logic                 start;
		logic [MUL_A_W-1:0]   a;
		logic [MUL_B_W-1:0]   b;
		logic [4:0]           digits;
	} mul_req_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_N_W-1:0]   num;
		logic [DIV_D_W-1:0]   den;
	} div_req_t;

	typedef enum logic [1:0] {
		CFG_THRESH,
		CFG_MIN_BEAT,
		CFG_MAX_BEAT,
		CFG_FALL
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_CHECK, ST_M_IRB, ST_M_IRS, ST_M_RB, ST_M_RS, ST_AC,
		ST_M_IRSQ, ST_M_RSQ, ST_M_HI, ST_M_AC82, ST_TRK_HI, ST_M_LO, ST_BEAT,
		ST_D_INST, ST_D_RATE, ST_CMP16, ST_D_RAT, ST_SQRT, ST_M_RMS, ST_D_RV,
		ST_M_RV2, ST_M_CB, ST_M_CA, ST_HIST, ST_SUM, ST_D_AVG, ST_FIN
	} state_t;

endpackage
`default_nettype wire

@@ src/pov_mul.sv @@
`default_nettype none
module pov_mul (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pov_pkg::mul_req_t req,
	output logic                   done,
	output logic [pov_pkg::MUL_P_W-1:0] prod
);
	import pov_pkg::*;

	logic               busy_q, done_q;
	logic [4:0]         cnt_q;
	logic [MUL_P_W-1:0] acc_q, a_sh_q, a3_sh_q, addend;
	logic [MUL_B_W-1:0] b_sh_q;

	// radix-4: one two-bit digit of b per cycle
	always_comb begin
		unique case (b_sh_q[1:0])
			2'd0: addend = '0;
			2'd1: addend = a_sh_q;
			2'd2: addend = {a_sh_q[MUL_P_W-2:0], 1'b0};
			2'd3: addend = a3_sh_q;
			default: addend = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.digits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q   <= '0;
			a_sh_q  <= MUL_P_W'(req.a);
			a3_sh_q <= MUL_P_W'(req.a) + (MUL_P_W'(req.a) << 1);
			b_sh_q  <= req.b;
		end else if (busy_q) begin
			acc_q   <= acc_q + addend;
			a_sh_q  <= {a_sh_q[MUL_P_W-3:0], 2'b00};
			a3_sh_q <= {a3_sh_q[MUL_P_W-3:0], 2'b00};
			b_sh_q  <= {2'b00, b_sh_q[MUL_B_W-1:2]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule
`default_nettype wire

@@ src/pov_div.sv @@
`default_nettype none
module pov_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pov_pkg::div_req_t req,
	output logic                   done,
	output logic [pov_pkg::DIV_N_W-1:0] quo
);
	import pov_pkg::*;

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_D_W-1:0]   rem_q, den_q;
	logic [DIV_N_W-1:0]   num_q;
	logic [DIV_D_W:0]     trial, diff;
	logic                 ge;

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, num_q[DIV_N_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_N_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			num_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			num_q <= {num_q[DIV_N_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule
`default_nettype wire

@@ src/pulse_oximeter_vitals.sv @@
`default_nettype none
// pulse oximeter vitals: takes one red/ir sample pair with a millisecond
// timestamp per transfer and returns one result per sample: smoothed heart
// rate, 5-beat averaged spo2, a beat flag and a finger flag. samples are
// processed one at a time by a sequencer around a radix-4 serial multiplier
// (one two-bit digit per cycle) and a restoring divider (one quotient bit per
// cycle). a sample without a finger is the quickest, and a sample that closes
// a valid beat takes longest, set mostly by the up to five divisions of the
// beat path. a new sample is accepted while the previous result still waits
// on the output register. configuration registers are written through the
// cfg port; the user must write them only while no sample is in flight, the
// block itself does not enforce this. cfg_ready is always high.
module pulse_oximeter_vitals (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [71:0] s_tdata,   // red_sample[17:0], ir_sample[35:18], time_ms[67:36]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata,   // heart_rate[7:0], spo2_percent[14:8],
	                                    // beat_accepted[15], finger_present[16]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [17:0] cfg_data
);
	import pov_pkg::*;

	// configuration registers
	logic [17:0] thr_q, fall_q;
	logic [15:0] min_q, max_q;

	// latched sample
	logic [SAMPLE_BITS-1:0] red_q, ir_q;
	logic [31:0]            now_q;

	// block state
	logic [BASE_W-1:0]  irb_q, redb_q;
	logic signed [31:0] hi_q, lo_q;
	logic               armed_q;
	logic [31:0]        last_q;
	logic [63:0]        rsum_q, isum_q;
	logic [HIST_W-1:0]  hist_q [HIST_DEPTH];
	logic [SLOT_W-1:0]  slot_q, idx_q;
	logic [7:0]         rate_q;
	logic [6:0]         spo2_q;
	logic               beat_q, finger_q;

	// sequencer scratch
	state_t             state_q, state_d;
	logic               launched_q;
	logic [63:0]        t0_q, t1_q;
	logic signed [31:0] irac_q, redac_q;
	logic [15:0]        inst_q;
	logic [HIST_W-1:0]  ent_q;
	logic [28:0]        sqv_q, sqr_q, sqb_q;
	logic [14:0]        rv_q;
	logic [SUM_W-1:0]   sum_q;

	// output register
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;

	mul_req_t            mul_req;
	div_req_t            div_req;
	logic                mul_done, div_done;
	logic [MUL_P_W-1:0]  mul_prod;
	logic [DIV_N_W-1:0]  div_quo;

	pov_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	pov_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (div_quo)
	);

	function automatic logic [31:0] mag32(input logic [31:0] x);
		return x[31] ? (~x + 32'd1) : x;
	endfunction

	// tracker update: sign-magnitude sum, round half away from zero, saturate
	function automatic logic [31:0] trk_upd(input logic [63:0] m0, input logic n0,
	                                        input logic [63:0] m1, input logic n1);
		logic signed [65:0] s0, s1, s, v;
		logic [65:0]        mag, rnd;
		s0  = n0 ? -$signed({2'b00, m0}) : $signed({2'b00, m0});
		s1  = n1 ? -$signed({2'b00, m1}) : $signed({2'b00, m1});
		s   = s0 + s1;
		mag = s[65] ? 66'(-s) : 66'(s);
		rnd = (mag + 66'd2048) >> FRAC_BITS;
		v   = s[65] ? -$signed(rnd) : $signed(rnd);
		if (v > 66'sd2147483647) return 32'h7fff_ffff;
		if (v < -66'sd2147483648) return 32'h8000_0000;
		return v[31:0];
	endfunction

	// datapath helpers
	logic [63:0]        ema_sum;
	logic [64:0]        sq_sum;
	logic signed [32:0] mid2, two_ac, fall_neg;
	logic               arm, rise, in_range;
	logic [31:0]        delta;
	logic [18:0]        rate_num;
	logic [15:0]        rate_base;
	logic               ge16, spo2_undef;
	logic [29:0]        sq_rb;
	logic signed [63:0] cal_v, cal_c;

	assign ema_sum  = t0_q + {mul_prod[51:0], 12'b0} + 64'd2048;
	assign sq_sum   = (state_q == ST_M_IRSQ) ?
	                  {1'b0, isum_q} + {13'b0, mul_prod[63:FRAC_BITS]} :
	                  {1'b0, rsum_q} + {13'b0, mul_prod[63:FRAC_BITS]};
	assign mid2     = {hi_q[31], hi_q} + {lo_q[31], lo_q};
	assign two_ac   = {irac_q, 1'b0};
	assign fall_neg = -$signed({3'b000, fall_q, 12'b0});
	assign arm      = (two_ac < mid2) && !armed_q &&
	                  ($signed({irac_q[31], irac_q}) < fall_neg);
	assign rise     = (two_ac > mid2) && armed_q;
	assign delta    = now_q - last_q;
	assign in_range = (delta > {16'b0, min_q}) && (delta < {16'b0, max_q});
	assign rate_base = (rate_q == 8'd0) ? inst_q : {8'b0, rate_q};
	assign rate_num  = {1'b0, rate_base, 2'b00} + {3'b000, inst_q};
	assign ge16       = {4'b0, rsum_q} >= {isum_q, 4'b0};
	assign spo2_undef = (isum_q == 64'd0) || (redb_q == '0);
	assign sq_rb     = {1'b0, sqr_q} + {1'b0, sqb_q};
	assign cal_c     = $signed({33'b0, COEF_C, 12'b0});
	assign cal_v     = cal_c + $signed(t1_q) - $signed(mul_prod);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (s_tvalid) state_d = ST_CHECK;
			ST_CHECK:  state_d = (ir_q < thr_q) ? ST_FIN : ST_M_IRB;
			ST_M_IRB:  if (mul_done) state_d = ST_M_IRS;
			ST_M_IRS:  if (mul_done) state_d = ST_M_RB;
			ST_M_RB:   if (mul_done) state_d = ST_M_RS;
			ST_M_RS:   if (mul_done) state_d = ST_AC;
			ST_AC:     state_d = ST_M_IRSQ;
			ST_M_IRSQ: if (mul_done) state_d = ST_M_RSQ;
			ST_M_RSQ:  if (mul_done) state_d = ST_M_HI;
			ST_M_HI:   if (mul_done) state_d = ST_M_AC82;
			ST_M_AC82: if (mul_done) state_d = ST_TRK_HI;
			ST_TRK_HI: state_d = ST_M_LO;
			ST_M_LO:   if (mul_done) state_d = ST_BEAT;
			ST_BEAT:   state_d = (rise && in_range) ? ST_D_INST : ST_FIN;
			ST_D_INST: if (div_done) state_d = ST_D_RATE;
			ST_D_RATE: if (div_done) state_d = spo2_undef ? ST_HIST : ST_CMP16;
			ST_CMP16:  state_d = ge16 ? ST_SQRT : ST_D_RAT;
			ST_D_RAT:  if (div_done) state_d = ST_SQRT;
			ST_SQRT:   if (sqb_q[0]) state_d = ST_M_RMS;
			ST_M_RMS:  if (mul_done) state_d = ST_D_RV;
			ST_D_RV:   if (div_done) state_d = ST_M_RV2;
			ST_M_RV2:  if (mul_done) state_d = ST_M_CB;
			ST_M_CB:   if (mul_done) state_d = ST_M_CA;
			ST_M_CA:   if (mul_done) state_d = ST_HIST;
			ST_HIST:   state_d = ST_SUM;
			ST_SUM:    if (idx_q == SLOT_W'(HIST_DEPTH - 1)) state_d = ST_D_AVG;
			ST_D_AVG:  if (div_done) state_d = ST_FIN;
			ST_FIN:    if (!m_tvalid_q || m_tready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// unit requests and handshake
	always_comb begin
		mul_req = '0;
		div_req = '0;
		s_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_M_IRB: begin
				mul_req.a = 32'(irb_q); mul_req.b = 32'(KEEP95); mul_req.digits = 5'd6;
			end
			ST_M_IRS: begin
				mul_req.a = 32'(ir_q); mul_req.b = 32'(NEW05); mul_req.digits = 5'd6;
			end
			ST_M_RB: begin
				mul_req.a = 32'(redb_q); mul_req.b = 32'(KEEP95); mul_req.digits = 5'd6;
			end
			ST_M_RS: begin
				mul_req.a = 32'(red_q); mul_req.b = 32'(NEW05); mul_req.digits = 5'd6;
			end
			ST_M_IRSQ: begin
				mul_req.a = mag32(irac_q); mul_req.b = mag32(irac_q); mul_req.digits = 5'd16;
			end
			ST_M_RSQ: begin
				mul_req.a = mag32(redac_q); mul_req.b = mag32(redac_q);
				mul_req.digits = 5'd16;
			end
			ST_M_HI: begin
				mul_req.a = mag32(hi_q); mul_req.b = 32'(KEEP98); mul_req.digits = 5'd6;
			end
			ST_M_AC82: begin
				mul_req.a = mag32(irac_q); mul_req.b = 32'(NEW02); mul_req.digits = 5'd6;
			end
			ST_M_LO: begin
				mul_req.a = mag32(lo_q); mul_req.b = 32'(KEEP98); mul_req.digits = 5'd6;
			end
			ST_M_RMS: begin
				mul_req.a = 32'(irb_q); mul_req.b = {17'b0, sqr_q[14:0]}; mul_req.digits = 5'd8;
			end
			ST_M_RV2: begin
				mul_req.a = 32'(rv_q); mul_req.b = 32'(rv_q); mul_req.digits = 5'd8;
			end
			ST_M_CB: begin
				mul_req.a = 32'(COEF_B); mul_req.b = 32'(rv_q); mul_req.digits = 5'd8;
			end
			ST_M_CA: begin
				mul_req.a = 32'(COEF_A); mul_req.b = {15'b0, t0_q[16:0]}; mul_req.digits = 5'd9;
			end
			ST_D_INST: begin
				div_req.num = DIV_N_W'(60000); div_req.den = {48'b0, delta[15:0]};
			end
			ST_D_RATE: begin
				div_req.num = DIV_N_W'(rate_num); div_req.den = DIV_D_W'(5);
			end
			ST_D_RAT: begin
				div_req.num = {rsum_q, 24'b0}; div_req.den = isum_q;
			end
			ST_D_RV: begin
				div_req.num = DIV_N_W'(t0_q); div_req.den = DIV_D_W'(redb_q);
			end
			ST_D_AVG: begin
				div_req.num = DIV_N_W'(sum_q);
				div_req.den = DIV_D_W'(HIST_DEPTH << HIST_FRAC);
			end
			default: ;
		endcase
		unique case (state_q)
			ST_M_IRB, ST_M_IRS, ST_M_RB, ST_M_RS, ST_M_IRSQ, ST_M_RSQ, ST_M_HI,
			ST_M_AC82, ST_M_LO, ST_M_RMS, ST_M_RV2, ST_M_CB, ST_M_CA:
				mul_req.start = !launched_q;
			ST_D_INST, ST_D_RATE, ST_D_RAT, ST_D_RV, ST_D_AVG:
				div_req.start = !launched_q;
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= 18'd50000;
			min_q  <= 16'd300;
			max_q  <= 16'd2000;
			fall_q <= 18'd10;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_THRESH:   thr_q  <= cfg_data;
				CFG_MIN_BEAT: min_q  <= cfg_data[15:0];
				CFG_MAX_BEAT: max_q  <= cfg_data[15:0];
				CFG_FALL:     fall_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer state and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			launched_q <= 1'b0;
			irb_q      <= '0;
			redb_q     <= '0;
			hi_q       <= 32'sd81920;   // +20.0
			lo_q       <= -32'sd81920;  // -20.0
			armed_q    <= 1'b0;
			last_q     <= '0;
			rsum_q     <= '0;
			isum_q     <= '0;
			for (int i = 0; i < HIST_DEPTH; i++) hist_q[i] <= '0;
			slot_q     <= '0;
			rate_q     <= '0;
			spo2_q     <= '0;
			beat_q     <= 1'b0;
			finger_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_req.start || div_req.start) launched_q <= 1'b1;
			else if (mul_done || div_done) launched_q <= 1'b0;

			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: beat_q <= 1'b0;
				ST_CHECK: begin
					if (ir_q < thr_q) begin
						// no finger: clear outputs and the ir baseline
						rate_q   <= '0;
						spo2_q   <= '0;
						irb_q    <= '0;
						finger_q <= 1'b0;
					end else begin
						finger_q <= 1'b1;
						// an empty baseline is first loaded with the sample
						if (irb_q == '0) irb_q <= {ir_q, 12'b0};
						if (redb_q == '0) redb_q <= {red_q, 12'b0};
					end
				end
				ST_M_IRS: if (mul_done) irb_q <= ema_sum[BASE_W+FRAC_BITS-1:FRAC_BITS];
				ST_M_RS:  if (mul_done) redb_q <= ema_sum[BASE_W+FRAC_BITS-1:FRAC_BITS];
				ST_M_IRSQ: if (mul_done) isum_q <= sq_sum[64] ? '1 : sq_sum[63:0];
				ST_M_RSQ:  if (mul_done) rsum_q <= sq_sum[64] ? '1 : sq_sum[63:0];
				ST_TRK_HI: hi_q <= trk_upd(t0_q, hi_q[31], t1_q, irac_q[31]);
				ST_M_LO:   if (mul_done) lo_q <= trk_upd(mul_prod, lo_q[31], t1_q, irac_q[31]);
				ST_BEAT: begin
					if (arm) armed_q <= 1'b1;
					if (rise) begin
						// every rise closing an armed beat restarts the interval
						armed_q <= 1'b0;
						if (!in_range) last_q <= now_q;
					end
				end
				// a valid beat restarts the interval once its length is taken
				ST_D_INST: if (div_done) last_q <= now_q;
				ST_D_RATE: if (div_done) rate_q <= (div_quo > DIV_N_W'(255)) ? 8'd255 : div_quo[7:0];
				ST_HIST: begin
					hist_q[slot_q] <= ent_q;
					slot_q <= (slot_q == SLOT_W'(HIST_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
				end
				ST_D_AVG: begin
					if (div_done) begin
						spo2_q <= div_quo[6:0];
						rsum_q <= '0;
						isum_q <= '0;
						beat_q <= 1'b1;
					end
				end
				ST_FIN: begin
					if (!m_tvalid_q || m_tready) m_tvalid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload and scratch registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			red_q <= s_tdata[17:0];
			ir_q  <= s_tdata[35:18];
			now_q <= s_tdata[67:36];
		end
		if (state_q == ST_FIN && (!m_tvalid_q || m_tready))
			m_tdata_q <= {7'b0, finger_q, beat_q, spo2_q, rate_q};

		unique case (state_q)
			ST_M_IRB, ST_M_RB, ST_M_HI, ST_M_RMS: if (mul_done) t0_q <= mul_prod;
			ST_M_AC82, ST_M_CB: if (mul_done) t1_q <= mul_prod;
			ST_M_RV2: if (mul_done) t0_q <= {12'b0, mul_prod[63:FRAC_BITS]};
			ST_AC: begin
				irac_q  <= $signed({2'b00, ir_q, 12'b0}) - $signed({2'b00, irb_q});
				redac_q <= $signed({2'b00, red_q, 12'b0}) - $signed({2'b00, redb_q});
			end
			ST_D_INST: if (div_done) inst_q <= div_quo[15:0];
			ST_D_RATE: if (div_done) ent_q <= HIST_W'(70 << HIST_FRAC);
			ST_CMP16: begin
				// ratio of squares capped at 16.0 in q.24
				if (ge16) sqv_q <= 29'h1000_0000;
				sqr_q <= '0;
				sqb_q <= 29'h1000_0000;
			end
			ST_D_RAT: if (div_done) sqv_q <= div_quo[28:0];
			ST_SQRT: begin
				if ({1'b0, sqv_q} >= sq_rb) begin
					sqv_q <= sqv_q - sq_rb[28:0];
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else begin
					sqr_q <= sqr_q >> 1;
				end
				sqb_q <= sqb_q >> 2;
			end
			ST_D_RV: if (div_done) rv_q <= (div_quo > DIV_N_W'(16384)) ? 15'd16384 : div_quo[14:0];
			ST_M_CA: begin
				if (mul_done) begin
					// clamp to 70..100 in q.24, keep q.8
					if (cal_v < 64'sd1174405120) ent_q <= HIST_W'(70 << HIST_FRAC);
					else if (cal_v > 64'sd1677721600) ent_q <= HIST_W'(100 << HIST_FRAC);
					else ent_q <= cal_v[30:16];
				end
			end
			ST_HIST: begin
				sum_q <= '0;
				idx_q <= '0;
			end
			ST_SUM: begin
				sum_q <= sum_q + SUM_W'(hist_q[idx_q]);
				idx_q <= idx_q + SLOT_W'(1);
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
`default_nettype wire
